// ----- src/bimap_pkg.sv -----
// ----------------------------------------------------------------------------
// bimap_pkg
// Shared types and constants of the bidirectional key/value map.
// ----------------------------------------------------------------------------
package bimap_pkg;

  // Fixed widths of the stream fields
  localparam int OPCODE_W = 4;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;

  // Default table index widths
  localparam int KEY_BITS_DEF   = 8;
  localparam int VALUE_BITS_DEF = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET         = 4'd0,
    OP_UPDATE      = 4'd1,
    OP_GET_VALUE   = 4'd2,
    OP_GET_KEY     = 4'd3,
    OP_HAS_KEY     = 4'd4,
    OP_HAS_VALUE   = 4'd5,
    OP_ERASE_KEY   = 4'd6,
    OP_ERASE_VALUE = 4'd7,
    OP_SWAP_KEYS   = 4'd8,
    OP_SWAP_VALUES = 4'd9
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_KEY_MISSING   = 3'd1,
    ST_KEY_MAPPED    = 3'd2,
    ST_VALUE_MISSING = 3'd3,
    ST_VALUE_MAPPED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_READ2,
    S_WRITE2
  } fsm_t;

endpackage

// ----- src/bimap_ram.sv -----
// ----------------------------------------------------------------------------
// bimap_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bimap_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bidirectional_id_remap_table_unit.sv -----
// ----------------------------------------------------------------------------
// bidirectional_id_remap_table_unit
// One-to-one key/value map held in a forward and a reverse table.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream: opcode in s_tuser, the key and value
//   operands in s_tdata. Every command yields exactly one result transfer on
//   the m_ stream: status in m_tuser, present / found value / found key in
//   m_tdata. A refused command reports its error status and changes nothing.
//   Both tables sit in RAMs with one write and one registered read port each,
//   so a command is a read-modify-write sequence. Set, get, has and erase
//   finish in the evaluate step, update goes on to a second write step (it
//   writes the reverse table twice) and swaps do two reads of one table,
//   then two writes; a refused update or swap ends before its last write.
//   The next command is taken in the cycle after the result is loaded.
//   After reset a clearing pass over 2**max(KEY_BITS, VALUE_BITS) addresses
//   invalidates every entry; s_tready stays low during it.
//   A result waits in the output register while m_tready is low; the
//   sequencer holds at its last step until the register frees up.
// ----------------------------------------------------------------------------
module bidirectional_id_remap_table_unit
  import bimap_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // first_key, second_key, first_value, second_value
  input  logic [31:0] s_tdata,
  // opcode
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // present, found_value, found_key, zero pad
  output logic [23:0] m_tdata,
  // status
  output logic [2:0]  m_tuser
);

  localparam int CLR_BITS = (KEY_BITS > VALUE_BITS) ? KEY_BITS : VALUE_BITS;
  localparam int FW       = VALUE_BITS + 1;  // forward entry: valid, value
  localparam int RW       = KEY_BITS + 1;    // reverse entry: valid, key

  fsm_t state, state_next;
  logic [CLR_BITS-1:0] clr_cnt;

  // Command registers
  opcode_t               op;
  logic [KEY_BITS-1:0]   k1, k2;
  logic [VALUE_BITS-1:0] v1, v2;
  logic                  a_fvld, a_rvld;
  logic [VALUE_BITS-1:0] a_val;
  logic [KEY_BITS-1:0]   a_key;

  // Incoming operands
  logic [KEY_BITS-1:0]   in_k1, in_k2;
  logic [VALUE_BITS-1:0] in_v1, in_v2;
  logic                  accept;

  // RAM ports
  logic                  f_we, f_re, r_we, r_re;
  logic [KEY_BITS-1:0]   f_waddr, f_raddr;
  logic [VALUE_BITS-1:0] r_waddr, r_raddr;
  logic [FW-1:0]         f_wdata, f_rdata;
  logic [RW-1:0]         r_wdata, r_rdata;

  logic                  f_vld, r_vld;
  logic [VALUE_BITS-1:0] f_part;
  logic [KEY_BITS-1:0]   r_part;

  // Result
  logic                  done, push;
  status_t               res_status;
  logic                  res_present;
  logic [VALUE_BITS-1:0] res_fval;
  logic [KEY_BITS-1:0]   res_fkey;

  status_t               out_status;
  logic                  out_present;
  logic [ID_W-1:0]       out_fval, out_fkey;

  assign in_k1  = KEY_BITS'(s_tdata[7:0]);
  assign in_k2  = KEY_BITS'(s_tdata[15:8]);
  assign in_v1  = VALUE_BITS'(s_tdata[23:16]);
  assign in_v2  = VALUE_BITS'(s_tdata[31:24]);
  assign accept = s_tvalid && s_tready;

  assign f_vld  = f_rdata[VALUE_BITS];
  assign f_part = f_rdata[VALUE_BITS-1:0];
  assign r_vld  = r_rdata[KEY_BITS];
  assign r_part = r_rdata[KEY_BITS-1:0];

  bimap_ram #(
    .WIDTH (FW),
    .DEPTH (1 << KEY_BITS)
  ) u_forward (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  bimap_ram #(
    .WIDTH (RW),
    .DEPTH (1 << VALUE_BITS)
  ) u_reverse (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= opcode_t'(s_tuser);
      k1 <= in_k1;
      k2 <= in_k2;
      v1 <= in_v1;
      v2 <= in_v2;
    end
    // Hold the first entry of a swap while the second is read
    if (state == S_EVAL) begin
      a_fvld <= f_vld;
      a_val  <= f_part;
      a_rvld <= r_vld;
      a_key  <= r_part;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    f_we        = 1'b0;
    f_waddr     = k1;
    f_wdata     = '0;
    f_re        = 1'b0;
    f_raddr     = in_k1;
    r_we        = 1'b0;
    r_waddr     = v1;
    r_wdata     = '0;
    r_re        = 1'b0;
    r_raddr     = in_v1;
    done        = 1'b0;
    res_status  = ST_OK;
    res_present = 1'b0;
    res_fval    = '0;
    res_fkey    = '0;

    case (state)
      S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = KEY_BITS'(clr_cnt);
        r_we    = 1'b1;
        r_waddr = VALUE_BITS'(clr_cnt);
        if (clr_cnt == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          f_re       = 1'b1;
          r_re       = 1'b1;
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        case (op)
          OP_SET: begin
            done = 1'b1;
            if (f_vld) begin
              res_status = ST_KEY_MAPPED;
            end else if (r_vld) begin
              res_status = ST_VALUE_MAPPED;
            end else begin
              f_we    = 1'b1;
              f_wdata = {1'b1, v1};
              r_we    = 1'b1;
              r_wdata = {1'b1, k1};
            end
          end
          OP_UPDATE: begin
            if (!f_vld) begin
              done       = 1'b1;
              res_status = ST_KEY_MISSING;
            end else if (r_vld) begin
              done       = 1'b1;
              res_status = ST_VALUE_MAPPED;
            end else begin
              // link the new pair now, release the old value next cycle
              f_we       = 1'b1;
              f_wdata    = {1'b1, v1};
              r_we       = 1'b1;
              r_wdata    = {1'b1, k1};
              state_next = S_WRITE2;
            end
          end
          OP_GET_VALUE: begin
            done = 1'b1;
            if (!f_vld) begin
              res_status = ST_KEY_MISSING;
            end else begin
              res_fval = f_part;
            end
          end
          OP_GET_KEY: begin
            done = 1'b1;
            if (!r_vld) begin
              res_status = ST_VALUE_MISSING;
            end else begin
              res_fkey = r_part;
            end
          end
          OP_HAS_KEY: begin
            done        = 1'b1;
            res_present = f_vld;
          end
          OP_HAS_VALUE: begin
            done        = 1'b1;
            res_present = r_vld;
          end
          OP_ERASE_KEY: begin
            done = 1'b1;
            if (!f_vld) begin
              res_status = ST_KEY_MISSING;
            end else begin
              f_we    = 1'b1;
              r_we    = 1'b1;
              r_waddr = f_part;
            end
          end
          OP_ERASE_VALUE: begin
            done = 1'b1;
            if (!r_vld) begin
              res_status = ST_VALUE_MISSING;
            end else begin
              r_we    = 1'b1;
              f_we    = 1'b1;
              f_waddr = r_part;
            end
          end
          OP_SWAP_KEYS: begin
            f_re       = 1'b1;
            f_raddr    = k2;
            state_next = S_READ2;
          end
          OP_SWAP_VALUES: begin
            r_re       = 1'b1;
            r_raddr    = v2;
            state_next = S_READ2;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_READ2: begin
        case (op)
          OP_SWAP_KEYS: begin
            if (!a_fvld || !f_vld) begin
              done       = 1'b1;
              res_status = ST_KEY_MISSING;
            end else begin
              // first key takes the second key's value
              f_we       = 1'b1;
              f_wdata    = {1'b1, f_part};
              r_we       = 1'b1;
              r_waddr    = f_part;
              r_wdata    = {1'b1, k1};
              state_next = S_WRITE2;
            end
          end
          OP_SWAP_VALUES: begin
            if (!a_rvld || !r_vld) begin
              done       = 1'b1;
              res_status = ST_VALUE_MISSING;
            end else begin
              // second value takes the first value's key
              r_we       = 1'b1;
              r_waddr    = v2;
              r_wdata    = {1'b1, a_key};
              f_we       = 1'b1;
              f_waddr    = a_key;
              f_wdata    = {1'b1, v2};
              state_next = S_WRITE2;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_WRITE2: begin
        done = 1'b1;
        case (op)
          OP_UPDATE: begin
            r_we    = 1'b1;
            r_waddr = f_part;
          end
          OP_SWAP_KEYS: begin
            f_we    = 1'b1;
            f_waddr = k2;
            f_wdata = {1'b1, a_val};
            r_we    = 1'b1;
            r_waddr = a_val;
            r_wdata = {1'b1, k2};
          end
          OP_SWAP_VALUES: begin
            r_we    = 1'b1;
            r_wdata = {1'b1, r_part};
            f_we    = 1'b1;
            f_waddr = r_part;
            f_wdata = {1'b1, v1};
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // Hold at the last step while the output register is full; the
    // writes of that step repeat with the same data.
    push = done && (!m_tvalid || m_tready);
    if (push) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_status  <= res_status;
      out_present <= res_present;
      out_fval    <= ID_W'(res_fval);
      out_fkey    <= ID_W'(res_fkey);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {7'd0, out_fkey, out_fval, out_present};

  // No command is taken during the clearing pass
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("command accepted during clearing pass");

  // A result is loaded only into a free or draining output register
  a_push_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending transfer");

  // A refused command never touches the tables
  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    (done && res_status != ST_OK) |-> (!f_we && !r_we))
    else $error("table written by a refused command");

  // An accepted command is evaluated in the next cycle with fresh read data
  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EVAL))
    else $error("accepted command not evaluated");

endmodule
